>>> rtl/monotonic_remote_timestamp_extrapolator_core_defines.svh
// ----------------------------------------------------------------------------
// Monotonic remote timestamp extrapolator - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MONOTONIC_REMOTE_TIMESTAMP_EXTRAPOLATOR_CORE_DEFINES_SVH
`define MONOTONIC_REMOTE_TIMESTAMP_EXTRAPOLATOR_CORE_DEFINES_SVH

// same-cycle implication
`define MRTE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrte assertion failed");

// next-cycle implication
`define MRTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrte assertion failed");

`endif

>>> rtl/mrte_pkg.sv
// ----------------------------------------------------------------------------
// mrte_pkg
// Types and constants shared by the timestamp extrapolator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mrte_pkg;

    localparam int STAMP_W = 64;
    localparam int AGE_W   = 32;
    localparam int OP_W    = 2;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 32'd500000;

    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic               source_is_dds;
        logic [STAMP_W-1:0] remote_stamp_us;
        logic [STAMP_W-1:0] local_time_us;
    } t_item;

    typedef struct packed {
        logic               ok;
        logic [STAMP_W-1:0] timestamp_us;
    } t_result;

    typedef struct packed {
        logic               last_valid;
        logic [STAMP_W-1:0] last_issued_us;
    } t_hist;

endpackage

`default_nettype wire

>>> rtl/mrte_in_stage.sv
// ----------------------------------------------------------------------------
// mrte_in_stage
// Input register: captures one item per transfer and holds it until the
// result stage can take its result.
// ----------------------------------------------------------------------------
`default_nettype none

module mrte_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire mrte_pkg::t_item i_item,
    input  wire logic           i_advance,
    output logic                o_ready,
    output logic                o_fire,
    output mrte_pkg::t_item     o_item
);
    import mrte_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_fire  = r_valid && i_advance;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrte_engine.sv
// ----------------------------------------------------------------------------
// mrte_engine
// Anchor and issue-history state with the single-pass update, query and
// clear logic. Also holds the age limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrte_engine (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mrte_pkg::AGE_W-1:0]      i_cfg_data,
    input  wire logic                            i_fire,
    input  wire mrte_pkg::t_item                 i_item,
    output mrte_pkg::t_result                    o_result,
    output mrte_pkg::t_hist                      o_hist
);
    import mrte_pkg::*;

    logic [AGE_W-1:0]   r_max_age;
    logic               r_anchor_valid;
    logic [STAMP_W-1:0] r_anchor_remote;
    logic [STAMP_W-1:0] r_anchor_local;
    logic               r_last_valid;
    logic [STAMP_W-1:0] r_last_issued;

    logic               n_anchor_valid;
    logic [STAMP_W-1:0] n_anchor_remote;
    logic [STAMP_W-1:0] n_anchor_local;
    logic               n_last_valid;
    logic [STAMP_W-1:0] n_last_issued;

    logic [STAMP_W:0]   elapsed;
    logic [STAMP_W:0]   sum;
    logic [STAMP_W-1:0] last_inc;
    logic               behind;
    logic               too_old;
    logic               need_bump;
    logic               q_ok;
    logic [STAMP_W-1:0] q_ts;
    logic               u_ok;

    always_comb begin
        elapsed   = {1'b0, i_item.local_time_us} - {1'b0, r_anchor_local};
        behind    = elapsed[STAMP_W];
        too_old   = (elapsed[STAMP_W-1:AGE_W] != '0) || (elapsed[AGE_W-1:0] > r_max_age);
        sum       = {1'b0, r_anchor_remote} + {{(STAMP_W-AGE_W+1){1'b0}}, elapsed[AGE_W-1:0]};
        last_inc  = r_last_issued + {{(STAMP_W-1){1'b0}}, 1'b1};
        need_bump = r_last_valid && (sum[STAMP_W-1:0] <= r_last_issued);
        q_ok      = (r_max_age != '0) && r_anchor_valid && !behind && !too_old
                    && !sum[STAMP_W] && !(need_bump && (&r_last_issued));
        q_ts      = need_bump ? last_inc : sum[STAMP_W-1:0];
        u_ok      = i_item.source_is_dds && (i_item.remote_stamp_us != '0)
                    && (!r_anchor_valid || (i_item.remote_stamp_us > r_anchor_remote));

        n_anchor_valid  = r_anchor_valid;
        n_anchor_remote = r_anchor_remote;
        n_anchor_local  = r_anchor_local;
        n_last_valid    = r_last_valid;
        n_last_issued   = r_last_issued;
        o_result        = '0;

        unique case (i_item.opcode)
            OP_UPDATE: begin
                o_result.ok = u_ok;
                if (u_ok) begin
                    n_anchor_valid  = 1'b1;
                    n_anchor_remote = i_item.remote_stamp_us;
                    n_anchor_local  = i_item.local_time_us;
                end
            end
            OP_QUERY: begin
                o_result.ok = q_ok;
                if (q_ok) begin
                    o_result.timestamp_us = q_ts;
                    n_last_valid          = 1'b1;
                    n_last_issued         = q_ts;
                end
            end
            OP_CLEAR: begin
                n_anchor_valid  = 1'b0;
                n_anchor_remote = '0;
                n_anchor_local  = '0;
                n_last_valid    = 1'b0;
                n_last_issued   = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_hist.last_valid     = r_last_valid;
    assign o_hist.last_issued_us = r_last_issued;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age      <= MAX_AGE_RESET;
            r_anchor_valid <= 1'b0;
            r_last_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_age <= i_cfg_data;
            end
            if (i_fire) begin
                r_anchor_valid <= n_anchor_valid;
                r_last_valid   <= n_last_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_anchor_remote <= n_anchor_remote;
            r_anchor_local  <= n_anchor_local;
            r_last_issued   <= n_last_issued;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrte_out_stage.sv
// ----------------------------------------------------------------------------
// mrte_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mrte_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire mrte_pkg::t_result i_result,
    input  wire logic              i_ready,
    output logic                   o_advance,
    output logic                   o_valid,
    output mrte_pkg::t_result      o_result
);
    import mrte_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/monotonic_remote_timestamp_extrapolator_core.sv
// ----------------------------------------------------------------------------
// monotonic_remote_timestamp_extrapolator_core
// Keeps a remote-clock anchor and issues strictly rising remote timestamps
// extrapolated from local time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one operation per transfer:
//   anchor update, timestamp query or clear. Output channel o_out_valid /
//   i_out_ready returns exactly one result (o_ok, o_timestamp_us) per item,
//   in order.
//   Each item passes through the input register and then the result
//   register. Throughput: one item per cycle when the output is not stalled;
//   the input register and the result register each hold one item, and all
//   64-bit subtract, add and compare work for an item sits between them.
//   i_cfg_we writes the age limit i_cfg_data in the same edge; write it only
//   while no item is in flight.
//   Reset (synchronous, active low) empties both registers, drops the anchor
//   and the issue history and sets the age limit to 500000 us.
//   Receiver stall: the result register holds; one more item may wait in the
//   input register, then o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "monotonic_remote_timestamp_extrapolator_core_defines.svh"

module monotonic_remote_timestamp_extrapolator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mrte_pkg::AGE_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [mrte_pkg::OP_W-1:0]     i_opcode,
    input  wire logic                          i_source_is_dds,
    input  wire logic [mrte_pkg::STAMP_W-1:0]  i_remote_stamp_us,
    input  wire logic [mrte_pkg::STAMP_W-1:0]  i_local_time_us,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_ok,
    output logic [mrte_pkg::STAMP_W-1:0]       o_timestamp_us
);
    import mrte_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    t_result eng_result;
    t_result out_result;
    t_hist   hist;
    logic    advance;
    logic    fire;

    assign in_item.opcode          = i_opcode;
    assign in_item.source_is_dds   = i_source_is_dds;
    assign in_item.remote_stamp_us = i_remote_stamp_us;
    assign in_item.local_time_us   = i_local_time_us;

    mrte_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (o_in_ready),
        .o_fire    (fire),
        .o_item    (stage_item)
    );

    mrte_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (stage_item),
        .o_result   (eng_result),
        .o_hist     (hist)
    );

    mrte_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (fire),
        .i_result  (eng_result),
        .i_ready   (i_out_ready),
        .o_advance (advance),
        .o_valid   (o_out_valid),
        .o_result  (out_result)
    );

    assign o_ok           = out_result.ok;
    assign o_timestamp_us = out_result.timestamp_us;

    `MRTE_ASSERT_NOW(a_refused_zero, o_out_valid && !o_ok, o_timestamp_us == '0)
    `MRTE_ASSERT_NOW(a_full_blocks, o_out_valid && !i_out_ready && !fire && !o_in_ready,
        !advance)
    `MRTE_ASSERT_NOW(a_monotonic,
        fire && (stage_item.opcode == OP_QUERY) && eng_result.ok && hist.last_valid,
        eng_result.timestamp_us > hist.last_issued_us)
    `MRTE_ASSERT_NEXT(a_history_tracks,
        fire && (stage_item.opcode == OP_QUERY) && eng_result.ok,
        hist.last_valid && (hist.last_issued_us == $past(eng_result.timestamp_us)))

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timestamp extrapolator core testbench
// Drives anchor updates, queries, clears and spare opcodes through the
// valid/ready input channel under several age limits, predicts each result
// from a behavioral copy of the anchor and issue history, and compares every
// output transfer in order. Both channels idle at random, with one long
// receiver hold and full drains before each age limit, mid-phase and at end.
// ----------------------------------------------------------------------------
module testbench;

    import mrte_pkg::*;

    localparam logic [OP_W-1:0]    OP_SPARE       = 2'd3;
    localparam logic [STAMP_W-1:0] STAMP_ONES     = {STAMP_W{1'b1}};
    localparam int                 WATCHDOG_LIMIT = 4000;
    localparam int                 PHASE_ITEMS    = 125;

    class stamp_scoreboard;
        logic [AGE_W-1:0]   age_limit;
        logic               has_anchor;
        logic [STAMP_W-1:0] anchor_remote;
        logic [STAMP_W-1:0] anchor_local;
        logic               has_issued;
        logic [STAMP_W-1:0] last_issued;
        t_result            expected_q[$];
        int                 errors;

        function new();
            age_limit = MAX_AGE_RESET;
            drop_anchor();
            errors = 0;
        endfunction

        function void drop_anchor();
            has_anchor    = 1'b0;
            anchor_remote = '0;
            anchor_local  = '0;
            has_issued    = 1'b0;
            last_issued   = '0;
        endfunction

        function void set_age_limit(logic [AGE_W-1:0] value);
            age_limit = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void predict_item(logic [OP_W-1:0] op, logic dds,
                                   logic [STAMP_W-1:0] stamp,
                                   logic [STAMP_W-1:0] local_us);
            t_result            res;
            logic [STAMP_W-1:0] elapsed;
            logic [STAMP_W-1:0] ts;
            logic               refused;
            res = '0;
            case (op)
                OP_UPDATE: begin
                    if (dds && stamp != '0 && !(has_anchor && stamp <= anchor_remote)) begin
                        has_anchor    = 1'b1;
                        anchor_remote = stamp;
                        anchor_local  = local_us;
                        res.ok        = 1'b1;
                    end
                end
                OP_QUERY: begin
                    refused = (age_limit == '0) || !has_anchor || (local_us < anchor_local);
                    elapsed = local_us - anchor_local;
                    if (!refused)
                        refused = (elapsed > {{(STAMP_W-AGE_W){1'b0}}, age_limit})
                                  || (anchor_remote > ~elapsed);
                    ts = anchor_remote + elapsed;
                    if (!refused && has_issued && ts <= last_issued) begin
                        refused = (last_issued == STAMP_ONES);
                        ts      = last_issued + STAMP_W'(1);
                    end
                    if (!refused) begin
                        has_issued       = 1'b1;
                        last_issued      = ts;
                        res.ok           = 1'b1;
                        res.timestamp_us = ts;
                    end
                end
                OP_CLEAR: drop_anchor();
                default: ;
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(logic ok_bit, logic [STAMP_W-1:0] ts);
            t_result exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result transfer ok=%0d ts=%h", $time, ok_bit, ts);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (ok_bit !== exp_res.ok) begin
                $display("%0t: ok mismatch expected %0d actual %0d", $time, exp_res.ok, ok_bit);
                errors++;
            end
            if (ts !== exp_res.timestamp_us) begin
                $display("%0t: timestamp_us mismatch expected %h actual %h",
                         $time, exp_res.timestamp_us, ts);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_cfg_we          = 1'b0;
    logic [AGE_W-1:0]     i_cfg_data        = '0;
    logic                 i_in_valid        = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_opcode          = OP_UPDATE;
    logic                 i_source_is_dds   = 1'b0;
    logic [STAMP_W-1:0]   i_remote_stamp_us = '0;
    logic [STAMP_W-1:0]   i_local_time_us   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready       = 1'b0;
    logic                 o_ok;
    logic [STAMP_W-1:0]   o_timestamp_us;

    stamp_scoreboard      sb;
    int unsigned          sender_gap  = 0;
    int unsigned          hold_len    = 0;
    bit                   no_idle     = 1'b0;
    int                   idle_cycles = 0;
    logic [AGE_W-1:0]     age_now     = MAX_AGE_RESET;
    logic [STAMP_W-1:0]   seq_stamp   = 64'd1000;
    logic [STAMP_W-1:0]   seq_local   = 64'd0;
    logic [STAMP_W-1:0]   anchor_hint = 64'd0;

    monotonic_remote_timestamp_extrapolator_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_source_is_dds   (i_source_is_dds),
        .i_remote_stamp_us (i_remote_stamp_us),
        .i_local_time_us   (i_local_time_us),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_ok              (o_ok),
        .o_timestamp_us    (o_timestamp_us)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic dds,
                             input logic [STAMP_W-1:0] stamp,
                             input logic [STAMP_W-1:0] local_us);
        repeat (sender_gap) @(posedge i_clk);
        i_opcode          <= op;
        i_source_is_dds   <= dds;
        i_remote_stamp_us <= stamp;
        i_local_time_us   <= local_us;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.predict_item(op, dds, stamp, local_us);
        sender_gap = no_idle ? 0 : $urandom_range(0, 4);
        if (sender_gap != 0)
            i_in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        if (sender_gap == 0)
            i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_age_limit(input logic [AGE_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_age_limit(value);
        age_now = value;
    endtask

    task automatic random_item(output logic [OP_W-1:0] op, output logic dds,
                               output logic [STAMP_W-1:0] stamp,
                               output logic [STAMP_W-1:0] local_us);
        int unsigned        pick;
        logic [STAMP_W-1:0] delta;
        pick     = $urandom_range(0, 99);
        op       = OP_QUERY;
        dds      = 1'($urandom_range(0, 1));
        stamp    = {$urandom, $urandom};
        local_us = seq_local;
        if (pick < 30) begin
            seq_stamp   = seq_stamp + STAMP_W'($urandom_range(1, 2000));
            seq_local   = seq_local + STAMP_W'($urandom_range(0, 2000));
            anchor_hint = seq_local;
            op          = OP_UPDATE;
            dds         = 1'b1;
            stamp       = seq_stamp;
            local_us    = seq_local;
        end else if (pick < 75) begin
            case ($urandom_range(0, 4))
                0: delta = '0;
                1: delta = STAMP_W'($urandom_range(0, 50));
                2: delta = {{(STAMP_W-AGE_W){1'b0}}, age_now};
                3: delta = {{(STAMP_W-AGE_W){1'b0}}, age_now} + STAMP_W'(1);
                default: delta = STAMP_W'($urandom_range(0, age_now));
            endcase
            local_us = anchor_hint + delta;
        end else if (pick < 80) begin
            op    = OP_UPDATE;
            dds   = 1'b1;
            stamp = seq_stamp - STAMP_W'($urandom_range(0, 5));
        end else if (pick < 84) begin
            op    = OP_UPDATE;
            dds   = 1'b0;
            stamp = seq_stamp + STAMP_W'($urandom_range(1, 100));
        end else if (pick < 86) begin
            op    = OP_UPDATE;
            dds   = 1'b1;
            stamp = '0;
        end else if (pick < 89) begin
            op = OP_CLEAR;
        end else if (pick < 91) begin
            op       = OP_SPARE;
            local_us = {$urandom, $urandom};
        end else if (pick < 94) begin
            local_us = anchor_hint - STAMP_W'($urandom_range(1, 100));
        end else if (pick < 97) begin
            op       = OP_W'($urandom_range(0, 3));
            local_us = {$urandom, $urandom};
        end else begin
            // restart the sequence from a fresh base, often near the top
            if ($urandom_range(0, 1))
                seq_stamp = STAMP_ONES - STAMP_W'($urandom_range(0, 3000));
            else
                seq_stamp = {$urandom, $urandom};
            seq_local   = {$urandom, $urandom};
            anchor_hint = seq_local;
            op          = OP_CLEAR;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles < WATCHDOG_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            $display("[monotonic_remote_timestamp_extrapolator_core] ERROR");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall    = (hold_len != 0) ? hold_len : (no_idle ? 0 : $urandom_range(0, 4));
            hold_len = 0;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_ok, o_timestamp_us);
        end
    end

    initial begin : stimulus
        logic [AGE_W-1:0]   age_plan[6];
        logic [OP_W-1:0]    op;
        logic               dds;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] local_us;
        sb = new();
        age_plan[0] = '0;
        age_plan[1] = {AGE_W{1'b1}};
        age_plan[2] = 32'd1;
        age_plan[3] = $urandom_range(100, 5000);
        age_plan[4] = $urandom;
        age_plan[5] = MAX_AGE_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_QUERY,  1'b1, 64'd0,    64'd0);
        send_item(OP_UPDATE, 1'b0, 64'd100,  64'd10);
        send_item(OP_UPDATE, 1'b1, 64'd0,    64'd10);
        send_item(OP_UPDATE, 1'b1, 64'd1000, 64'd5000);
        send_item(OP_UPDATE, 1'b1, 64'd1000, 64'd6000);
        send_item(OP_UPDATE, 1'b1, 64'd999,  64'd6000);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd4999);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd5000);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd5000);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd505000);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd505001);
        send_item(OP_SPARE,  1'b1, STAMP_ONES, STAMP_ONES);
        send_item(OP_CLEAR,  1'b1, STAMP_ONES, STAMP_ONES);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd5000);
        send_item(OP_UPDATE, 1'b1, STAMP_ONES - 64'd10, 64'd0);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd11);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd10);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd10);
        send_item(OP_QUERY,  1'b0, 64'd0,    64'd0);
        send_item(OP_CLEAR,  1'b0, 64'd0,    64'd0);
        send_item(OP_UPDATE, 1'b1, STAMP_ONES, STAMP_ONES);
        send_item(OP_QUERY,  1'b1, STAMP_ONES, STAMP_ONES);
        send_item(OP_UPDATE, 1'b1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_CLEAR,  1'b0, 64'd0,    64'd0);

        for (int p = 0; p < 6; p++) begin
            drain_results();
            write_age_limit(age_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                no_idle = (n >= 40 && n < 70);
                if (p == 1 && n == 40)
                    hold_len = 60;
                if (p == 2 && n == 60)
                    drain_results();
                random_item(op, dds, stamp, local_us);
                send_item(op, dds, stamp, local_us);
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[monotonic_remote_timestamp_extrapolator_core] OK");
        else
            $display("[monotonic_remote_timestamp_extrapolator_core] ERROR");
        $finish;
    end

endmodule
